@@ src/wshc_pkg.sv @@
// wshc_pkg: shared constants and types for the window size hint constrainer.
// No dependencies; used by wshc_rem_pipe, wshc_lane and the top level.
package wshc_pkg;

    // Remainder operands handled side by side in each lane
    localparam int REM_OPS = 3;
    localparam int OP_VAL  = 0;   // clamped request minus base
    localparam int OP_LO   = 1;   // effective minimum minus base
    localparam int OP_HI   = 2;   // distance between effective maximum and base

    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BASE_WIDTH  = 3'd0,
        REG_BASE_HEIGHT = 3'd1,
        REG_MIN_WIDTH   = 3'd2,
        REG_MIN_HEIGHT  = 3'd3,
        REG_MAX_WIDTH   = 3'd4,
        REG_MAX_HEIGHT  = 3'd5,
        REG_WIDTH_STEP  = 3'd6,
        REG_HEIGHT_STEP = 3'd7
    } cfg_reg_t;

endpackage

@@ src/wshc_rem_pipe.sv @@
// wshc_rem_pipe: pipelined restoring remainder, one dividend bit per stage,
// several dividends against one static divisor. Depends on wshc_pkg.
module wshc_rem_pipe #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] divisor,
    input  logic [W-1:0] dvd_in  [wshc_pkg::REM_OPS],
    output logic [W-1:0] rem_out [wshc_pkg::REM_OPS]
);

    logic [W-1:0] rem_reg   [W][wshc_pkg::REM_OPS];
    logic [W-1:0] dvd_reg   [W][wshc_pkg::REM_OPS];
    logic [W-1:0] rem_prev  [W][wshc_pkg::REM_OPS];
    logic [W-1:0] dvd_prev  [W][wshc_pkg::REM_OPS];
    logic [W-1:0] rem_next  [W][wshc_pkg::REM_OPS];

    always_comb
    begin
        logic [W:0] trial;
        for (int o = 0; o < wshc_pkg::REM_OPS; o++)
        begin
            rem_prev[0][o] = '0;
            dvd_prev[0][o] = dvd_in[o];
        end
        for (int s = 1; s < W; s++)
        begin
            for (int o = 0; o < wshc_pkg::REM_OPS; o++)
            begin
                rem_prev[s][o] = rem_reg[s-1][o];
                dvd_prev[s][o] = dvd_reg[s-1][o];
            end
        end
        // stage s brings in dividend bit W-1-s, MSB first
        for (int s = 0; s < W; s++)
        begin
            for (int o = 0; o < wshc_pkg::REM_OPS; o++)
            begin
                trial = {rem_prev[s][o], dvd_prev[s][o][W-1-s]};
                if (trial >= {1'b0, divisor})
                begin
                    trial = trial - {1'b0, divisor};
                end
                rem_next[s][o] = trial[W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < W; s++)
            begin
                for (int o = 0; o < wshc_pkg::REM_OPS; o++)
                begin
                    rem_reg[s][o] <= rem_next[s][o];
                    dvd_reg[s][o] <= dvd_prev[s][o];
                end
            end
        end
    end

    always_comb
    begin
        for (int o = 0; o < wshc_pkg::REM_OPS; o++)
        begin
            rem_out[o] = rem_reg[W-1][o];
        end
    end

endmodule

@@ src/wshc_lane.sv @@
// wshc_lane: one axis of the size constrainer (clamp, snap, re-round).
// Depends on wshc_pkg and wshc_rem_pipe.
module wshc_lane #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] base_size,
    input  logic [W-1:0] min_size,
    input  logic [W-1:0] max_size,
    input  logic [W-1:0] step_size,
    input  logic [W-1:0] req,
    input  logic         fit,
    output logic [W-1:0] res,
    output logic [W-1:0] raw
);

    // config-derived values; the user must keep them static while items are in flight, the lane does not enforce it
    logic [W-1:0] min_eff;
    logic [W-1:0] lo;
    logic [W-1:0] lo_minus_base;
    logic [W-1:0] step_eff;
    logic [W:0]   lo_step;

    assign min_eff       = (min_size == '0) ? W'(1) : min_size;
    assign lo            = (base_size > min_eff) ? base_size : min_eff;
    assign lo_minus_base = lo - base_size;
    assign step_eff      = (step_size == '0) ? W'(1) : step_size;
    assign lo_step       = {1'b0, lo} + {1'b0, step_eff};

    // stage 0: maximum clamp and effective maximum
    logic [W-1:0] v1_next, hi0_next;
    logic [W-1:0] v1_reg, hi0_reg, raw0_reg;

    // clamp to the hint maximum; a make-fit maximum is the request capped by any hint maximum and never clips it
    assign v1_next  = ((max_size != '0) && (req > max_size)) ? max_size : req;
    assign hi0_next = (fit && ((req < max_size) || (max_size == '0))) ? req : max_size;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg   <= v1_next;
            hi0_reg  <= hi0_next;
            raw0_reg <= req;
        end
    end

    // stage 1: minimum clamp and distances from base
    logic         v1_lt_lo;
    logic         hilt_next;
    logic [W-1:0] v2_next;
    logic [W-1:0] dvd_next [wshc_pkg::REM_OPS];
    logic [W-1:0] dvd_reg  [wshc_pkg::REM_OPS];
    logic [W-1:0] v2_reg, hi1_reg, raw1_reg;
    logic         hilt1_reg;

    assign v1_lt_lo  = v1_reg < lo;
    assign hilt_next = hi0_reg < base_size;
    assign v2_next   = v1_lt_lo ? lo : v1_reg;

    always_comb
    begin
        dvd_next[wshc_pkg::OP_VAL] = v1_lt_lo ? lo_minus_base : (v1_reg - base_size);
        dvd_next[wshc_pkg::OP_LO]  = lo_minus_base;
        dvd_next[wshc_pkg::OP_HI]  = hilt_next ? (base_size - hi0_reg) : (hi0_reg - base_size);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvd_reg   <= dvd_next;
            v2_reg    <= v2_next;
            hi1_reg   <= hi0_reg;
            hilt1_reg <= hilt_next;
            raw1_reg  <= raw0_reg;
        end
    end

    // remainders by the increment
    logic [W-1:0] rem [wshc_pkg::REM_OPS];

    wshc_rem_pipe #(
        .W (W)
    ) u_rem (
        .clk     (clk),
        .en      (en),
        .divisor (step_eff),
        .dvd_in  (dvd_reg),
        .rem_out (rem)
    );

    // side data delayed to match the remainder pipeline
    logic [W-1:0] v2_dl_reg  [W];
    logic [W-1:0] hi_dl_reg  [W];
    logic [W-1:0] raw_dl_reg [W];
    logic [W-1:0] hilt_dl_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v2_dl_reg[0]   <= v2_reg;
            hi_dl_reg[0]   <= hi1_reg;
            raw_dl_reg[0]  <= raw1_reg;
            hilt_dl_reg[0] <= hilt1_reg;
            for (int s = 1; s < W; s++)
            begin
                v2_dl_reg[s]   <= v2_dl_reg[s-1];
                hi_dl_reg[s]   <= hi_dl_reg[s-1];
                raw_dl_reg[s]  <= raw_dl_reg[s-1];
                hilt_dl_reg[s] <= hilt_dl_reg[s-1];
            end
        end
    end

    // stage A: snapped-down, rounded-up and re-rounded-down candidates
    logic [W-1:0] hi_d;
    logic [W-1:0] a_next, c_next;
    logic [W:0]   b_next;
    logic [W-1:0] a_reg, c_reg, hia_reg, rawa_reg;
    logic [W:0]   b_reg;

    assign hi_d   = hi_dl_reg[W-1];
    assign a_next = v2_dl_reg[W-1] - rem[wshc_pkg::OP_VAL];
    assign b_next = (rem[wshc_pkg::OP_LO] == '0) ? {1'b0, lo}
                                                 : (lo_step - {1'b0, rem[wshc_pkg::OP_LO]});
    // maximum below base: truncation toward zero moves up toward the base
    assign c_next = hilt_dl_reg[W-1] ? (hi_d + rem[wshc_pkg::OP_HI])
                                     : (hi_d - rem[wshc_pkg::OP_HI]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            hia_reg  <= hi_d;
            rawa_reg <= raw_dl_reg[W-1];
        end
    end

    // stage B (feeds the output register): pick the candidate.
    // Only the round-down from the maximum can reach zero (base 0 and a
    // maximum under one increment); it is lifted to 1.
    logic a_lt_lo, a_gt_hi, b_gt_hi, hi_set;
    logic [W-1:0] c_fix;

    assign a_lt_lo = a_reg < lo;
    assign a_gt_hi = a_reg > hia_reg;
    assign b_gt_hi = b_reg > {1'b0, hia_reg};
    assign hi_set  = hia_reg != '0;
    assign c_fix   = (c_reg == '0) ? W'(1) : c_reg;

    always_comb
    begin
        if (a_lt_lo)
        begin
            if (hi_set && b_gt_hi)
            begin
                res = c_fix;
            end
            else if (b_reg[W])
            begin
                res = '1;
            end
            else
            begin
                res = b_reg[W-1:0];
            end
        end
        else if (hi_set && a_gt_hi)
        begin
            res = c_fix;
        end
        else
        begin
            res = a_reg;
        end
    end

    assign raw = rawa_reg;

endmodule

@@ src/window_size_hint_constrainer.sv @@
// window_size_hint_constrainer: top level, config registers, lane control,
// merge and output skid buffer. Depends on wshc_pkg and wshc_lane.
//
// Constrains a requested window size by size hints held in eight config
// registers (base, minimum, maximum and resize increment per axis; write 0
// for an absent hint). One item can enter per cycle while s_axis_tready is
// high; each result reaches the master side through the lane stages and the
// output register, the remainder pipeline resolving one dividend bit per
// stage for the increment snapping. Width and height run in two identical
// lanes whose results are merged in the output register; a request with a
// zero dimension is returned unchanged. A skid register behind the output
// lets the pipeline keep taking items while a result waits, and s_axis_tready
// falls only once both output slots are full. Config writes are always
// accepted and must only be issued while no item is in flight.
module window_size_hint_constrainer #(
    parameter int DIM_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wshc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [DIM_BITS-1:0]               cfg_data,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // req_width, req_height, zero fill to a whole byte
    input  logic [((2*DIM_BITS+7)/8)*8-1:0]   s_axis_tdata,
    // fit_mode
    input  logic                              s_axis_tuser,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_width, out_height, zero fill to a whole byte
    output logic [((2*DIM_BITS+7)/8)*8-1:0]   m_axis_tdata
);

    localparam int LAT = DIM_BITS + 3;   // lane stages up to the output register

    // ---------------- configuration registers ----------------
    logic [DIM_BITS-1:0] base_width_reg, base_height_reg;
    logic [DIM_BITS-1:0] min_width_reg, min_height_reg;
    logic [DIM_BITS-1:0] max_width_reg, max_height_reg;
    logic [DIM_BITS-1:0] width_step_reg, height_step_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_width_reg  <= '0;
            base_height_reg <= '0;
            min_width_reg   <= '0;
            min_height_reg  <= '0;
            max_width_reg   <= '0;
            max_height_reg  <= '0;
            width_step_reg  <= '0;
            height_step_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (wshc_pkg::cfg_reg_t'(cfg_index))
                wshc_pkg::REG_BASE_WIDTH:  base_width_reg  <= cfg_data;
                wshc_pkg::REG_BASE_HEIGHT: base_height_reg <= cfg_data;
                wshc_pkg::REG_MIN_WIDTH:   min_width_reg   <= cfg_data;
                wshc_pkg::REG_MIN_HEIGHT:  min_height_reg  <= cfg_data;
                wshc_pkg::REG_MAX_WIDTH:   max_width_reg   <= cfg_data;
                wshc_pkg::REG_MAX_HEIGHT:  max_height_reg  <= cfg_data;
                wshc_pkg::REG_WIDTH_STEP:  width_step_reg  <= cfg_data;
                wshc_pkg::REG_HEIGHT_STEP: height_step_reg <= cfg_data;
            endcase
        end
    end

    // output register and skid slot state, used by the pipeline control
    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    logic                park;
    logic [DIM_BITS-1:0] out_width_reg, out_height_reg;
    logic [DIM_BITS-1:0] skid_width_reg, skid_height_reg;

    // ---------------- pipeline control ----------------
    // Whole pipeline shifts together; it halts only while the skid slot is full.
    logic                en;
    logic [DIM_BITS-1:0] req_width, req_height;
    logic                in_zero;
    logic [LAT-1:0]      vld_reg, zero_reg;

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;
    assign req_width     = s_axis_tdata[DIM_BITS-1:0];
    assign req_height    = s_axis_tdata[2*DIM_BITS-1:DIM_BITS];
    assign in_zero       = (req_width == '0) || (req_height == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    // pass-through mark rides along with each item
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg <= {zero_reg[LAT-2:0], in_zero};
        end
    end

    // ---------------- lanes ----------------
    logic [DIM_BITS-1:0] res_width, res_height, raw_width, raw_height;

    wshc_lane #(
        .W (DIM_BITS)
    ) u_lane_width (
        .clk       (clk),
        .en        (en),
        .base_size (base_width_reg),
        .min_size  (min_width_reg),
        .max_size  (max_width_reg),
        .step_size (width_step_reg),
        .req       (req_width),
        .fit       (s_axis_tuser),
        .res       (res_width),
        .raw       (raw_width)
    );

    wshc_lane #(
        .W (DIM_BITS)
    ) u_lane_height (
        .clk       (clk),
        .en        (en),
        .base_size (base_height_reg),
        .min_size  (min_height_reg),
        .max_size  (max_height_reg),
        .step_size (height_step_reg),
        .req       (req_height),
        .fit       (s_axis_tuser),
        .res       (res_height),
        .raw       (raw_height)
    );

    // ---------------- merge ----------------
    logic [DIM_BITS-1:0] merge_width, merge_height;

    assign merge_width  = zero_reg[LAT-1] ? raw_width  : res_width;
    assign merge_height = zero_reg[LAT-1] ? raw_height : res_height;

    // ---------------- output register and skid slot ----------------
    // a result arriving while the output is held goes to the skid slot
    assign park = out_valid_reg && !m_axis_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (en)
        begin
            if (park)
            begin
                skid_valid_next = vld_reg[LAT-1];
            end
            else
            begin
                out_valid_next = vld_reg[LAT-1];
            end
        end
        else if (m_axis_tready)
        begin
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (park)
            begin
                skid_width_reg  <= merge_width;
                skid_height_reg <= merge_height;
            end
            else
            begin
                out_width_reg  <= merge_width;
                out_height_reg <= merge_height;
            end
        end
        else if (m_axis_tready)
        begin
            out_width_reg  <= skid_width_reg;
            out_height_reg <= skid_height_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;

    always_comb
    begin
        m_axis_tdata                         = '0;
        m_axis_tdata[DIM_BITS-1:0]           = out_width_reg;
        m_axis_tdata[2*DIM_BITS-1:DIM_BITS]  = out_height_reg;
    end

    // ---------------- assertions ----------------
    // skid slot only ever holds the second of two waiting results
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full while output register empty");

    // a result leaving the lanes into a held output must be parked, not dropped
    a_result_parked: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[LAT-1] && out_valid_reg && !m_axis_tready) |=> skid_valid_reg)
        else $error("result lost while output stalled");

    // the skid slot fills only behind a stalled output
    a_skid_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready))
        else $error("skid slot filled without a stalled output");

endmodule
